>>> rtl/dau_pkg.sv
`default_nettype none

package dau_pkg;

    // Field widths and calendar limits
    localparam int YEAR_BITS  = 14;
    localparam int COUNT_BITS = 16;
    localparam int DELTA_BITS = 14;
    localparam int OP_BITS    = 3;
    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;

    localparam logic [YEAR_BITS-1:0] MIN_YEAR = YEAR_BITS'(1600);
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

    // Exact-division test by 25: y * inv(25) mod 2^W <= (2^W - 1) / 25
    localparam logic [YEAR_BITS-1:0] INV25     = YEAR_BITS'(32'hC28F5C29);
    localparam logic [YEAR_BITS-1:0] DIV25_LIM = YEAR_BITS'(YEAR_MAX / 25);

    // Opcodes of the input word
    localparam logic [OP_BITS-1:0] OP_CHECK     = 3'd0;
    localparam logic [OP_BITS-1:0] OP_NEXT_DAY  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_ADD_DAYS  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_SUB_DAYS  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_ADD_YEARS = 3'd4;

    // Commands passed from the front to the back
    localparam logic [1:0] CMD_PASS  = 2'd0;
    localparam logic [1:0] CMD_FWD   = 2'd1;
    localparam logic [1:0] CMD_BACK  = 2'd2;
    localparam logic [1:0] CMD_YEARS = 2'd3;

    // Month codes used by the month-length lookup
    localparam logic [MONTH_BITS-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_BITS-1:0] DAY_FEB_LEAP = 5'd29;
    localparam logic [DAY_BITS-1:0] DAY_FEB      = 5'd28;
    localparam logic [DAY_BITS-1:0] DAY_SHORT    = 5'd30;
    localparam logic [DAY_BITS-1:0] DAY_LONG     = 5'd31;
    localparam logic [DAY_BITS-1:0] DAY_FIRST    = 5'd1;

    // Queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    // One classified word in the queue
    typedef struct packed {
        logic [1:0]                   cmd;
        logic                         ok;
        logic [DAY_BITS-1:0]          day;
        logic [MONTH_BITS-1:0]        month;
        logic [YEAR_BITS-1:0]         year;
        logic [COUNT_BITS-1:0]        count;
        logic signed [DELTA_BITS-1:0] delta;
    } dau_entry_t;

    // Leap year by the 400/100/4 rule
    function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
        logic [YEAR_BITS-1:0] p;
        logic div25;
        p = YEAR_BITS'(y * INV25);
        div25 = (p <= DIV25_LIM);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // Length of a month (1..12)
    function automatic logic [DAY_BITS-1:0] days_in(input logic [MONTH_BITS-1:0] m,
                                                   input logic leap);
        logic [DAY_BITS-1:0] len;
        case (m)
            MON_FEB: len = leap ? DAY_FEB_LEAP : DAY_FEB;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_SHORT;
            default: len = DAY_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dau_front.sv
`default_nettype none

module dau_front
    import dau_pkg::*;
(
    input  wire logic [OP_BITS-1:0]          opcode,
    input  wire logic [DAY_BITS-1:0]         day_in,
    input  wire logic [MONTH_BITS-1:0]       month_in,
    input  wire logic [YEAR_BITS-1:0]        year_in,
    input  wire logic [COUNT_BITS-1:0]       day_count,
    input  wire logic signed [DELTA_BITS-1:0] year_delta,
    output dau_entry_t                       entry
);

    logic                ok;
    logic [DAY_BITS-1:0] mlen;

    // Check the date against the calendar
    always_comb
    begin
        mlen = days_in(month_in, is_leap(year_in));
        ok = (year_in >= MIN_YEAR) && (month_in >= MON_JAN) && (month_in <= MON_DEC)
             && (day_in >= DAY_FIRST) && (day_in <= mlen);
    end

    // Classify the word into a back-end command
    always_comb
    begin
        entry.ok    = ok;
        entry.day   = day_in;
        entry.month = month_in;
        entry.year  = year_in;
        entry.count = day_count;
        entry.delta = year_delta;
        entry.cmd   = CMD_PASS;
        if (ok)
        begin
            case (opcode)
                OP_NEXT_DAY:
                begin
                    entry.cmd   = CMD_FWD;
                    entry.count = COUNT_BITS'(1);
                end
                OP_ADD_DAYS:  entry.cmd = CMD_FWD;
                OP_SUB_DAYS:  entry.cmd = CMD_BACK;
                OP_ADD_YEARS: entry.cmd = CMD_YEARS;
                default:      entry.cmd = CMD_PASS;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/dau_queue.sv
`default_nettype none

module dau_queue
    import dau_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire dau_entry_t push_data,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output dau_entry_t      head
);

    dau_entry_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]         count_reg, count_next;

    assign full      = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the stored words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dau_back.sv
`default_nettype none

module dau_back
    import dau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire dau_entry_t             q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [DAY_BITS-1:0]         day_out,
    output logic [MONTH_BITS-1:0]       month_out,
    output logic [YEAR_BITS-1:0]        year_out,
    output logic                        date_valid,
    output logic                        out_of_range
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int SUM_W = YEAR_BITS + 2;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   cmd_reg, cmd_next;
    logic                         ok_reg, ok_next;
    logic                         oor_reg, oor_next;
    logic [DAY_BITS-1:0]          d_reg, d_next;
    logic [MONTH_BITS-1:0]        m_reg, m_next;
    logic [YEAR_BITS-1:0]         y_reg, y_next;
    logic [COUNT_BITS-1:0]        n_reg, n_next;
    logic [DAY_BITS-1:0]          d0_reg, d0_next;
    logic [MONTH_BITS-1:0]        m0_reg, m0_next;
    logic [YEAR_BITS-1:0]         y0_reg, y0_next;
    logic signed [DELTA_BITS-1:0] delta_reg, delta_next;

    logic                         out_valid_reg, out_valid_next;
    logic [DAY_BITS-1:0]          day_out_reg, day_out_next;
    logic [MONTH_BITS-1:0]        month_out_reg, month_out_next;
    logic [YEAR_BITS-1:0]         year_out_reg, year_out_next;
    logic                         date_valid_reg, date_valid_next;
    logic                         oor_out_reg, oor_out_next;

    logic signed [SUM_W-1:0]      year_sum;
    logic                         sum_oor;
    logic [YEAR_BITS-1:0]         leap_year;
    logic                         leap;
    logic [DAY_BITS-1:0]          mlen;
    logic [DAY_BITS-1:0]          rem;
    logic [MONTH_BITS-1:0]        m_dec;

    assign q_pop        = (state_reg == ST_IDLE) && q_valid;
    assign out_valid    = out_valid_reg;
    assign day_out      = day_out_reg;
    assign month_out    = month_out_reg;
    assign year_out     = year_out_reg;
    assign date_valid   = date_valid_reg;
    assign out_of_range = oor_out_reg;

    // Shared calendar arithmetic for one step
    always_comb
    begin
        year_sum  = $signed({2'b00, y_reg}) + SUM_W'(delta_reg);
        sum_oor   = (year_sum < 0) || (year_sum > $signed({2'b00, YEAR_MAX}));
        leap_year = (cmd_reg == CMD_YEARS) ? year_sum[YEAR_BITS-1:0] : y_reg;
        leap      = is_leap(leap_year);
        m_dec     = m_reg - 1'b1;
        mlen      = days_in((cmd_reg == CMD_BACK) ? m_dec : m_reg, leap);
        rem       = days_in(m_reg, leap) - d_reg;
    end

    // Step the date one month at a time for day counts, add years directly, and hand the result on
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ok_next         = ok_reg;
        oor_next        = oor_reg;
        d_next          = d_reg;
        m_next          = m_reg;
        y_next          = y_reg;
        n_next          = n_reg;
        d0_next         = d0_reg;
        m0_next         = m0_reg;
        y0_next         = y0_reg;
        delta_next      = delta_reg;
        out_valid_next  = out_valid_reg;
        day_out_next    = day_out_reg;
        month_out_next  = month_out_reg;
        year_out_next   = year_out_reg;
        date_valid_next = date_valid_reg;
        oor_out_next    = oor_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next   = q_head.cmd;
                    ok_next    = q_head.ok;
                    oor_next   = 1'b0;
                    d_next     = q_head.day;
                    m_next     = q_head.month;
                    y_next     = q_head.year;
                    n_next     = q_head.count;
                    d0_next    = q_head.day;
                    m0_next    = q_head.month;
                    y0_next    = q_head.year;
                    delta_next = q_head.delta;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (cmd_reg)
                    CMD_FWD:
                    begin
                        if (n_reg <= COUNT_BITS'(rem))
                        begin
                            d_next     = d_reg + DAY_BITS'(n_reg);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            n_next = n_reg - COUNT_BITS'(rem) - 1'b1;
                            d_next = DAY_FIRST;
                            if (m_reg == MON_DEC)
                            begin
                                if (y_reg == YEAR_MAX)
                                begin
                                    oor_next   = 1'b1;
                                    d_next     = d0_reg;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    m_next = MON_JAN;
                                    y_next = y_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                m_next = m_reg + 1'b1;
                            end
                        end
                    end
                    CMD_BACK:
                    begin
                        if (n_reg < COUNT_BITS'(d_reg))
                        begin
                            d_next     = d_reg - DAY_BITS'(n_reg);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            n_next = n_reg - COUNT_BITS'(d_reg);
                            if (m_reg == MON_JAN)
                            begin
                                if (y_reg == '0)
                                begin
                                    oor_next   = 1'b1;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    m_next = MON_DEC;
                                    y_next = y_reg - 1'b1;
                                    d_next = DAY_LONG;
                                end
                            end
                            else
                            begin
                                m_next = m_dec;
                                d_next = mlen;
                            end
                        end
                    end
                    CMD_YEARS:
                    begin
                        if (sum_oor)
                        begin
                            oor_next = 1'b1;
                        end
                        else
                        begin
                            y_next = year_sum[YEAR_BITS-1:0];
                            if ((d_reg == DAY_FEB_LEAP) && (m_reg == MON_FEB) && !leap)
                            begin
                                d_next = DAY_FEB;
                            end
                        end
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    day_out_next    = oor_reg ? d0_reg : d_reg;
                    month_out_next  = oor_reg ? m0_reg : m_reg;
                    year_out_next   = oor_reg ? y0_reg : y_reg;
                    date_valid_next = ok_reg;
                    oor_out_next    = oor_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working date and result word
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ok_reg         <= ok_next;
        oor_reg        <= oor_next;
        d_reg          <= d_next;
        m_reg          <= m_next;
        y_reg          <= y_next;
        n_reg          <= n_next;
        d0_reg         <= d0_next;
        m0_reg         <= m0_next;
        y0_reg         <= y0_next;
        delta_reg      <= delta_next;
        day_out_reg    <= day_out_next;
        month_out_reg  <= month_out_next;
        year_out_reg   <= year_out_next;
        date_valid_reg <= date_valid_next;
        oor_out_reg    <= oor_out_next;
    end

endmodule

`default_nettype wire

>>> rtl/date_arithmetic_unit_core.sv
// Gregorian date arithmetic unit.
// Input channel (in_valid/in_ready) carries opcode, a date and the operands:
// check, next day, add days, subtract days, add signed years. Output channel
// (out_valid/out_ready) returns one word per input: the date, date_valid and
// out_of_range.
// A front stage checks and classifies each word straight into a two-entry
// queue; in_ready is high whenever the queue has room. The back end walks
// the calendar one month per cycle (a single day step for next day).
// Check, add years and invalid dates pass straight through the run state;
// day arithmetic stays in it while it walks the months crossed. The back end
// takes a new word only after its last one is in the output register.
// The result sits in an output register; while the receiver stalls the back
// end holds its finished word and the queue keeps taking input until full.
// Reset clears the queue, the back-end state and out_valid; no clearing
// pass is needed.
`default_nettype none

module date_arithmetic_unit_core
    import dau_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [OP_BITS-1:0]           opcode,
    input  wire logic [DAY_BITS-1:0]          day_in,
    input  wire logic [MONTH_BITS-1:0]        month_in,
    input  wire logic [YEAR_BITS-1:0]         year_in,
    input  wire logic [COUNT_BITS-1:0]        day_count,
    input  wire logic signed [DELTA_BITS-1:0] year_delta,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [DAY_BITS-1:0]               day_out,
    output logic [MONTH_BITS-1:0]             month_out,
    output logic [YEAR_BITS-1:0]              year_out,
    output logic                              date_valid,
    output logic                              out_of_range
);

    dau_entry_t entry;
    dau_entry_t head;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;

    assign in_ready = !q_full;

    dau_front u_front (
        .opcode     (opcode),
        .day_in     (day_in),
        .month_in   (month_in),
        .year_in    (year_in),
        .day_count  (day_count),
        .year_delta (year_delta),
        .entry      (entry)
    );

    dau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !q_full),
        .push_data  (entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (head)
    );

    dau_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day_out      (day_out),
        .month_out    (month_out),
        .year_out     (year_out),
        .date_valid   (date_valid),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

>>> verif/date_arithmetic_unit_checker.sv
module date_arithmetic_unit_checker
    import dau_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [OP_BITS-1:0]           opcode,
    input  wire logic [DAY_BITS-1:0]          day_in,
    input  wire logic [MONTH_BITS-1:0]        month_in,
    input  wire logic [YEAR_BITS-1:0]         year_in,
    input  wire logic [COUNT_BITS-1:0]        day_count,
    input  wire logic signed [DELTA_BITS-1:0] year_delta,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [DAY_BITS-1:0]          day_out,
    input  wire logic [MONTH_BITS-1:0]        month_out,
    input  wire logic [YEAR_BITS-1:0]         year_out,
    input  wire logic                         date_valid,
    input  wire logic                         out_of_range,
    output int                                errors,
    output int                                waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_TOP = 2 ** YEAR_BITS - 1;

    typedef struct packed {
        logic [DAY_BITS-1:0]   day;
        logic [MONTH_BITS-1:0] month;
        logic [YEAR_BITS-1:0]  year;
        logic                  valid;
        logic                  oor;
    } date_result_t;

    // Predicted result words, oldest first
    date_result_t expected_dates[$];

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int month_length(input int m, input int y);
        int len;
        case (m)
            int'(MON_FEB): len = leap_year(y) ? 29 : 28;
            int'(MON_APR), int'(MON_JUN), int'(MON_SEP), int'(MON_NOV): len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    function automatic date_result_t predict_date(
        input logic [OP_BITS-1:0]           op,
        input logic [DAY_BITS-1:0]          d0,
        input logic [MONTH_BITS-1:0]        m0,
        input logic [YEAR_BITS-1:0]         y0,
        input logic [COUNT_BITS-1:0]        cnt,
        input logic signed [DELTA_BITS-1:0] dlt
    );
        int d;
        int m;
        int y;
        int n;
        int rest;
        bit ok;
        bit in_range;
        date_result_t r;
        d = int'(d0);
        m = int'(m0);
        y = int'(y0);
        n = 0;
        in_range = 1'b1;
        ok = (y >= int'(MIN_YEAR)) && (m >= 1) && (m <= 12) && (d >= 1)
            && (d <= month_length(m, y));
        if (ok)
        begin
            case (op)
                OP_NEXT_DAY, OP_ADD_DAYS:
                begin
                    n = (op == OP_NEXT_DAY) ? 1 : int'(cnt);
                    // advance a month at a time until the count fits
                    while (n > 0 && in_range)
                    begin
                        rest = month_length(m, y) - d;
                        if (n <= rest)
                        begin
                            d = d + n;
                            n = 0;
                        end
                        else
                        begin
                            n = n - rest - 1;
                            d = 1;
                            m = m + 1;
                            if (m > 12)
                            begin
                                m = 1;
                                y = y + 1;
                                if (y > YEAR_TOP)
                                    in_range = 1'b0;
                            end
                        end
                    end
                end
                OP_SUB_DAYS:
                begin
                    n = int'(cnt);
                    // step back to the last day of each earlier month
                    while (n > 0 && in_range)
                    begin
                        if (n < d)
                        begin
                            d = d - n;
                            n = 0;
                        end
                        else
                        begin
                            n = n - d;
                            m = m - 1;
                            if (m < 1)
                            begin
                                m = 12;
                                y = y - 1;
                                if (y < 0)
                                    in_range = 1'b0;
                            end
                            d = month_length(m, y);
                        end
                    end
                end
                OP_ADD_YEARS:
                begin
                    y = int'(y0) + int'(dlt);
                    if (y < 0 || y > YEAR_TOP)
                        in_range = 1'b0;
                    else if (d == 29 && m == int'(MON_FEB) && !leap_year(y))
                        d = 28;
                end
                default: ;
            endcase
            // keep the input date when the year falls off either end
            if (!in_range)
            begin
                d = int'(d0);
                m = int'(m0);
                y = int'(y0);
            end
        end
        r.day   = DAY_BITS'(d);
        r.month = MONTH_BITS'(m);
        r.year  = YEAR_BITS'(y);
        r.valid = ok;
        r.oor   = !in_range;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Queue a prediction per accepted word, check each result word in order
    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_dates.push_back(predict_date(opcode, day_in, month_in, year_in,
                                                      day_count, year_delta));
            if (out_valid && out_ready)
            begin
                if (expected_dates.size() == 0)
                begin
                    errors++;
                    $display("%0t: extra result word: expected none, got %0d-%0d-%0d v%0d r%0d",
                             $time, year_out, month_out, day_out, date_valid, out_of_range);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    compare_field("day_out", int'(want.day), int'(day_out));
                    compare_field("month_out", int'(want.month), int'(month_out));
                    compare_field("year_out", int'(want.year), int'(year_out));
                    compare_field("date_valid", int'(want.valid), int'(date_valid));
                    compare_field("out_of_range", int'(want.oor), int'(out_of_range));
                end
            end
            waiting = expected_dates.size();
        end
    end

endmodule

>>> verif/date_arithmetic_unit_core_tb.sv
module date_arithmetic_unit_core_tb
    import dau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_WORDS    = 75;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;

    // Top of the opcode field; codes above add years behave as check
    localparam logic [OP_BITS-1:0] OP_HIGHEST = 3'd7;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [OP_BITS-1:0]           opcode;
    logic [DAY_BITS-1:0]          day_in;
    logic [MONTH_BITS-1:0]        month_in;
    logic [YEAR_BITS-1:0]         year_in;
    logic [COUNT_BITS-1:0]        day_count;
    logic signed [DELTA_BITS-1:0] year_delta;
    logic                         out_valid;
    logic                         out_ready;
    logic [DAY_BITS-1:0]          day_out;
    logic [MONTH_BITS-1:0]        month_out;
    logic [YEAR_BITS-1:0]         year_out;
    logic                         date_valid;
    logic                         out_of_range;
    int                           errors;
    int                           waiting;
    int                           accepted_words;
    int                           cycle_count;
    bit                           sender_calm;

    date_arithmetic_unit_core i_dut (.*);

    date_arithmetic_unit_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one word from a falling edge and hold it until accepted
    task automatic send_word(
        input logic [OP_BITS-1:0]           op,
        input logic [DAY_BITS-1:0]          d,
        input logic [MONTH_BITS-1:0]        m,
        input logic [YEAR_BITS-1:0]         y,
        input logic [COUNT_BITS-1:0]        cnt,
        input logic signed [DELTA_BITS-1:0] dlt
    );
        int gap;
        gap = pick_gap(sender_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        day_in     <= d;
        month_in   <= m;
        year_in    <= y;
        day_count  <= cnt;
        year_delta <= dlt;
        do
            @(posedge clk);
        while (!in_ready);
        accepted_words++;
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [OP_BITS-1:0]           op;
        logic [DAY_BITS-1:0]          d;
        logic [MONTH_BITS-1:0]        m;
        logic [YEAR_BITS-1:0]         y;
        logic [COUNT_BITS-1:0]        cnt;
        logic signed [DELTA_BITS-1:0] dlt;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_CHECK;
        day_in         = '0;
        month_in       = '0;
        year_in        = '0;
        day_count      = '0;
        year_delta     = '0;
        accepted_words = 0;
        sender_calm    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // validity: good date, bad day, bad month, early year, leap Februaries
        send_word(OP_CHECK, 5'd15, 4'd6, 14'd2024, 16'd0, 14'sd0);
        send_word(OP_CHECK, 5'd0, 4'd1, 14'd2000, 16'd0, 14'sd0);
        send_word(OP_CHECK, 5'd31, 4'd4, 14'd2000, 16'd0, 14'sd0);
        send_word(OP_ADD_DAYS, 5'd1, 4'd0, 14'd2000, 16'd100, 14'sd0);
        send_word(OP_CHECK, 5'd1, 4'd13, 14'd2000, 16'd0, 14'sd0);
        send_word(OP_CHECK, 5'd31, 4'd15, 14'd16383, 16'hFFFF, -14'sd8192);
        send_word(OP_CHECK, 5'd1, 4'd1, 14'd1599, 16'd0, 14'sd0);
        send_word(OP_CHECK, 5'd29, 4'd2, 14'd1900, 16'd0, 14'sd0);
        send_word(OP_CHECK, 5'd29, 4'd2, 14'd2000, 16'd0, 14'sd0);
        // next day: off the top year, into March, into a leap day
        send_word(OP_NEXT_DAY, 5'd31, 4'd12, 14'd16383, 16'd0, 14'sd0);
        send_word(OP_NEXT_DAY, 5'd28, 4'd2, 14'd2023, 16'd0, 14'sd0);
        send_word(OP_NEXT_DAY, 5'd28, 4'd2, 14'd2024, 16'd0, 14'sd0);
        // day counts: largest, zero, past the top year; largest and zero subtracted
        send_word(OP_ADD_DAYS, 5'd1, 4'd1, 14'd1600, 16'hFFFF, 14'sd0);
        send_word(OP_ADD_DAYS, 5'd10, 4'd5, 14'd2020, 16'd0, 14'sd0);
        send_word(OP_ADD_DAYS, 5'd20, 4'd12, 14'd16383, 16'd20, 14'sd0);
        send_word(OP_SUB_DAYS, 5'd1, 4'd1, 14'd1600, 16'hFFFF, 14'sd0);
        send_word(OP_SUB_DAYS, 5'd15, 4'd3, 14'd2000, 16'd0, 14'sd0);
        // years: leap day clamp, leap day kept, both ends, zero, below 1600
        send_word(OP_ADD_YEARS, 5'd29, 4'd2, 14'd2000, 16'd0, 14'sd1);
        send_word(OP_ADD_YEARS, 5'd29, 4'd2, 14'd2000, 16'd0, -14'sd400);
        send_word(OP_ADD_YEARS, 5'd1, 4'd1, 14'd1600, 16'd0, -14'sd8192);
        send_word(OP_ADD_YEARS, 5'd31, 4'd12, 14'd16383, 16'd0, 14'sd8191);
        send_word(OP_ADD_YEARS, 5'd5, 4'd5, 14'd2000, 16'd0, 14'sd0);
        send_word(OP_ADD_YEARS, 5'd10, 4'd10, 14'd2000, 16'd0, -14'sd1500);
        // spare opcodes
        for (int k = OP_ADD_YEARS + 1; k <= OP_HIGHEST; k++)
            send_word(OP_BITS'(k), 5'd31, 4'd12, 14'd2000, 16'd1, 14'sd1);

        // random words, mostly well-formed dates with random operands
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 20 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
                0:       op = OP_CHECK;
                1:       op = OP_NEXT_DAY;
                2, 3:    op = OP_ADD_DAYS;
                4, 5:    op = OP_SUB_DAYS;
                6, 7:    op = OP_ADD_YEARS;
                8:       op = OP_BITS'($urandom_range(OP_ADD_YEARS + 1, OP_HIGHEST));
                default: op = OP_BITS'($urandom());
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                d = DAY_BITS'($urandom());
                m = MONTH_BITS'($urandom());
                y = YEAR_BITS'($urandom());
            end
            else
            begin
                d = ($urandom_range(0, 3) == 0) ? DAY_BITS'($urandom_range(28, 31))
                                                : DAY_BITS'($urandom_range(1, 28));
                m = MONTH_BITS'($urandom_range(1, 12));
                case ($urandom_range(0, 9))
                    0:       y = YEAR_BITS'(MIN_YEAR + $urandom_range(0, 100));
                    1:       y = YEAR_BITS'(YEAR_MAX - $urandom_range(0, 12));
                    default: y = YEAR_BITS'($urandom_range(MIN_YEAR, YEAR_MAX));
                endcase
            end
            case ($urandom_range(0, 15))
                0:       cnt = COUNT_BITS'($urandom());
                1:       cnt = '0;
                default: cnt = COUNT_BITS'($urandom_range(1, 400));
            endcase
            if ($urandom_range(0, 3) == 0)
                dlt = DELTA_BITS'($urandom());
            else
                dlt = DELTA_BITS'(int'($urandom_range(0, 1200)) - 600);
            send_word(op, d, m, y, cnt, dlt);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then allow a little slack for stray words
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, calm stretches and one long hold-off
    initial
    begin
        int stall;
        bit calm;
        bit held_off;
        out_ready = 1'b0;
        calm      = 1'b0;
        held_off  = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!held_off && accepted_words >= HOLD_OFF_AFTER)
            begin
                // hold off long enough for the queue to fill and stall the sender
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                if ($urandom_range(0, 31) == 0)
                    calm = !calm;
                stall = pick_gap(calm);
                out_ready <= (stall == 0);
                repeat ((stall == 0) ? $urandom_range(1, 6) : stall) @(negedge clk);
            end
        end
    end

    // Drop the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
